[sv/i64da_pkg.sv]
// ----------------------------------------------------------------------------
// i64da_pkg
// Shared types and constants for the signed integer to decimal text core.
// ----------------------------------------------------------------------------
package i64da_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int MAG_W       = VALUE_WIDTH;
  // digits of the largest magnitude 2^(VALUE_WIDTH-1), floor((W-1)*log10(2))+1
  localparam int DIG_N       = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BCD_W       = DIG_N * 4;
  // double dabble takes four magnitude bits per cycle
  localparam int STEP_N      = (VALUE_WIDTH + 3) / 4;
  localparam int PAD_W       = STEP_N * 4;
  localparam int CNT_W       = $clog2(STEP_N);
  localparam int IDX_W       = $clog2(DIG_N);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } item_t;

  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] bcd;
  } bcd_item_t;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_RUN,
    CV_DONE
  } conv_state_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_SIGN,
    EM_DIGIT
  } emit_state_t;

endpackage

[sv/i64da_front.sv]
// ----------------------------------------------------------------------------
// i64da_front
// Accepts input items, splits them into sign and magnitude, and holds them
// in a two-entry queue for the converter.
// ----------------------------------------------------------------------------
module i64da_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [63:0]           in_tdata,   // [63:0] value
  output logic                  q_valid,
  input  logic                  q_ready,
  output i64da_pkg::item_t      q_item
);

  logic [i64da_pkg::VALUE_WIDTH-1:0] v;
  i64da_pkg::item_t                  cls;
  i64da_pkg::item_t                  q_item_r [2];
  logic                              wr_ptr_r, wr_ptr_nxt;
  logic                              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]                        q_cnt_r, q_cnt_nxt;
  logic                              push, pop;

  // bits above the value width are ignored; magnitude of the most negative
  // value comes out right in the unsigned domain
  always_comb begin
    v       = in_tdata[i64da_pkg::VALUE_WIDTH-1:0];
    cls.neg = v[i64da_pkg::VALUE_WIDTH-1];
    cls.mag = cls.neg ? (~v + i64da_pkg::MAG_W'(1)) : v;
  end

  assign in_tready = (q_cnt_r != 2'd2);
  assign q_valid   = (q_cnt_r != 2'd0);
  assign q_item    = q_item_r[rd_ptr_r];
  assign push      = in_tvalid & in_tready;
  assign pop       = q_valid & q_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    q_cnt_nxt  = q_cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      q_cnt_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_item_r[wr_ptr_r] <= cls;
    end
  end

endmodule

[sv/i64da_conv.sv]
// ----------------------------------------------------------------------------
// i64da_conv
// Binary magnitude to packed BCD by shift-and-add-3, four bits per cycle.
// ----------------------------------------------------------------------------
module i64da_conv (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  i64da_pkg::item_t       in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output i64da_pkg::bcd_item_t   out_item
);

  i64da_pkg::conv_state_t          state_r, state_nxt;
  logic [i64da_pkg::PAD_W-1:0]     bin_r, bin_nxt;
  logic [i64da_pkg::BCD_W-1:0]     bcd_r, bcd_nxt;
  logic                            neg_r, neg_nxt;
  logic [i64da_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [i64da_pkg::PAD_W-1:0]     bin_s;
  logic [i64da_pkg::BCD_W-1:0]     bcd_s;

  // four dependent dabble steps on the current registers
  always_comb begin
    bin_s = bin_r;
    bcd_s = bcd_r;
    for (int s = 0; s < 4; s++) begin
      for (int d = 0; d < i64da_pkg::DIG_N; d++) begin
        if (bcd_s[d*4 +: 4] >= 4'd5) begin
          bcd_s[d*4 +: 4] = bcd_s[d*4 +: 4] + 4'd3;
        end
      end
      bcd_s = {bcd_s[i64da_pkg::BCD_W-2:0], bin_s[i64da_pkg::PAD_W-1]};
      bin_s = {bin_s[i64da_pkg::PAD_W-2:0], 1'b0};
    end
  end

  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      i64da_pkg::CV_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          bin_nxt   = i64da_pkg::PAD_W'(in_item.mag);
          bcd_nxt   = '0;
          neg_nxt   = in_item.neg;
          cnt_nxt   = i64da_pkg::CNT_W'(i64da_pkg::STEP_N - 1);
          state_nxt = i64da_pkg::CV_RUN;
        end
      end
      i64da_pkg::CV_RUN: begin
        bin_nxt = bin_s;
        bcd_nxt = bcd_s;
        if (cnt_r == '0) begin
          state_nxt = i64da_pkg::CV_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      i64da_pkg::CV_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = i64da_pkg::CV_IDLE;
        end
      end
      default: state_nxt = i64da_pkg::CV_IDLE;
    endcase
  end

  assign out_item.neg = neg_r;
  assign out_item.bcd = bcd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= i64da_pkg::CV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

[sv/i64da_emit.sv]
// ----------------------------------------------------------------------------
// i64da_emit
// Walks a BCD number from its top significant digit down, emitting one ASCII
// character per item through an output register.
// ----------------------------------------------------------------------------
module i64da_emit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  i64da_pkg::bcd_item_t   in_item,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata,  // [7:0] char_code
  output logic                   out_tlast
);

  i64da_pkg::emit_state_t          state_r, state_nxt;
  logic [i64da_pkg::BCD_W-1:0]     bcd_r, bcd_nxt;
  logic [i64da_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic                            ovalid_r, ovalid_nxt;
  logic [7:0]                      odata_r, odata_nxt;
  logic                            olast_r, olast_nxt;
  logic [i64da_pkg::IDX_W-1:0]     top_idx;
  logic                            adv;
  logic [3:0]                      digit;

  // highest nonzero digit; zero keeps index 0 and prints a single '0'
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < i64da_pkg::DIG_N; i++) begin
      if (in_item.bcd[i*4 +: 4] != 4'd0) begin
        top_idx = i64da_pkg::IDX_W'(i);
      end
    end
  end

  assign adv   = !ovalid_r || out_tready;
  assign digit = bcd_r[idx_r*4 +: 4];

  always_comb begin
    state_nxt  = state_r;
    bcd_nxt    = bcd_r;
    idx_nxt    = idx_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    in_ready   = 1'b0;
    unique case (state_r)
      i64da_pkg::EM_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          bcd_nxt   = in_item.bcd;
          idx_nxt   = top_idx;
          state_nxt = in_item.neg ? i64da_pkg::EM_SIGN : i64da_pkg::EM_DIGIT;
        end
      end
      i64da_pkg::EM_SIGN: begin
        if (adv) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = i64da_pkg::CHAR_MINUS;
          olast_nxt  = 1'b0;
          state_nxt  = i64da_pkg::EM_DIGIT;
        end
      end
      i64da_pkg::EM_DIGIT: begin
        if (adv) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = i64da_pkg::CHAR_ZERO + {4'd0, digit};
          olast_nxt  = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = i64da_pkg::EM_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: state_nxt = i64da_pkg::EM_IDLE;
    endcase
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= i64da_pkg::EM_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bcd_r   <= bcd_nxt;
    idx_r   <= idx_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

endmodule

[sv/int64_to_decimal_ascii_core.sv]
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii_core
// Signed two's complement integer to decimal ASCII text, one character per
// output item.
// ----------------------------------------------------------------------------
// Each input item is one signed integer; the core returns its decimal text,
// most significant character first, with a leading '-' for negative values
// and tlast on the final digit (1 to 20 items per number). The front splits
// sign and magnitude into a two-entry queue; the converter does a load, 16
// shift-and-add-3 steps of four bits and a hand-off per number; the emitter
// sends one character per cycle from a registered output while out_tready
// accepts them. Converter and emitter overlap, so the rate of a steady stream
// is set by the longer of the BCD conversion and the character count.
module int64_to_decimal_ascii_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] char_code
  output logic        out_tlast
);

  logic                  q_valid, q_ready;
  i64da_pkg::item_t      q_item;
  logic                  c_valid, c_ready;
  i64da_pkg::bcd_item_t  c_item;

  i64da_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  i64da_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_item  (c_item)
  );

  i64da_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (c_valid),
    .in_ready   (c_ready),
    .in_item    (c_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef NO_ASSERTIONS
  // a minus sign never ends a number
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata == i64da_pkg::CHAR_MINUS) |-> !out_tlast)
    else $error("minus sign flagged as last character");

  // only digits and the minus sign are produced
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata == i64da_pkg::CHAR_MINUS) ||
                   ((out_tdata >= 8'h30) && (out_tdata <= 8'h39)))
    else $error("character outside digit and minus set");

  // a character after the sign is a significant digit, never '0'
  a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && (out_tdata == i64da_pkg::CHAR_MINUS)
    |=> !(out_tvalid && (out_tdata == i64da_pkg::CHAR_ZERO)))
    else $error("leading zero after minus sign");
`endif

endmodule

[verif/int64_to_decimal_ascii_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii_core_test
// Checks the decimal text produced for signed 64-bit integers.
// ----------------------------------------------------------------------------
// A table of directed numbers (zero, both extremes, digit-count edges, sign
// patterns) is sent first, then a few hundred random numbers of every digit
// count. Each accepted number is turned into its expected characters, which
// are queued and compared in order with the output items. Both sides idle in
// random bursts, and the output is held off for a long stretch once so that
// the core backs up and stalls its input.
// ----------------------------------------------------------------------------
module int64_to_decimal_ascii_core_test;

  localparam int RANDOM_N   = 360;
  localparam int QUIET_N    = 60;    // final random items sent with no idling
  localparam int LONG_HOLD  = 600;
  localparam int DRAIN_WAIT = 40;
  localparam int CYCLE_CAP  = 400000;
  localparam int DIR_N      = 22;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  text_char_t  text_q[$];
  int          err_cnt    = 0;
  int          num_cnt    = 0;
  int          char_cnt   = 0;
  int          cycle_cnt  = 0;
  int          tx_odds    = 0;
  int          rx_odds    = 0;
  bit          quiet      = 1'b0;
  bit          hold_req   = 1'b0;
  bit          hold_done  = 1'b0;

  logic [63:0] dir_value [DIR_N];
  string       dir_text  [DIR_N];

  int64_to_decimal_ascii_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("int64_to_decimal_ascii_core_test failed");
      $finish;
    end
  end

  // queue the characters of the decimal text of one number
  function automatic void predict_decimal(input logic [63:0] raw);
    logic [i64da_pkg::VALUE_WIDTH-1:0] value;
    logic [i64da_pkg::VALUE_WIDTH-1:0] mag;
    logic [7:0]                        digits[$];
    text_char_t                        tc;
    logic                              neg;

    value = raw[i64da_pkg::VALUE_WIDTH-1:0];
    neg   = value[i64da_pkg::VALUE_WIDTH-1];
    // unsigned negate: the most negative value maps to 2^(W-1) exactly
    mag   = neg ? (~value + 1'b1) : value;
    do begin
      digits.push_front(i64da_pkg::CHAR_ZERO + 8'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (neg) begin
      tc.code = i64da_pkg::CHAR_MINUS;
      tc.last = 1'b0;
      text_q.push_back(tc);
    end
    foreach (digits[i]) begin
      tc.code = digits[i];
      tc.last = (i == digits.size() - 1);
      text_q.push_back(tc);
    end
  endfunction

  function automatic void push_text(input string s);
    text_char_t tc;
    for (int i = 0; i < s.len(); i++) begin
      tc.code = s[i];
      tc.last = (i == s.len() - 1);
      text_q.push_back(tc);
    end
  endfunction

  task automatic send_number(input logic [63:0] value, input string text);
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (in_tready !== 1'b1);
    if (text.len() != 0) push_text(text);
    else predict_decimal(value);
    num_cnt++;
    if (!quiet && tx_odds != 0 && $urandom_range(0, tx_odds) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] pow_of_ten(input int k);
    logic [63:0] p;
    p = 64'd1;
    repeat (k) p = p * 10;
    return p;
  endfunction

  function automatic logic [63:0] random_number();
    logic [63:0] v;
    logic [63:0] p;
    int          kind;

    kind = $urandom_range(0, 9);
    if (kind <= 3) begin
      v = {$urandom, $urandom};
    end else if (kind <= 6) begin
      // uniform over one digit count, 1 to 19 digits
      p = pow_of_ten($urandom_range(0, 18));
      v = p + ({$urandom, $urandom} % (p * 9));
      if ($urandom_range(0, 1)) v = -v;
    end else if (kind == 7) begin
      v = 64'($urandom_range(0, 20));
      if ($urandom_range(0, 1)) v = -v;
    end else if (kind == 8) begin
      if ($urandom_range(0, 1)) v = 64'h7FFF_FFFF_FFFF_FFFF - $urandom_range(0, 50);
      else v = 64'h8000_0000_0000_0000 + $urandom_range(0, 50);
    end else begin
      v = pow_of_ten($urandom_range(0, 18)) + $urandom_range(0, 2) - 1;
      if ($urandom_range(0, 1)) v = -v;
    end
    return v;
  endfunction

  // output check, on pre-edge values
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (text_q.size() == 0) begin
        $error("unexpected item: char_code %h last %b", out_tdata, out_tlast);
        err_cnt++;
      end else begin
        if (out_tdata !== text_q[0].code) begin
          $error("char_code mismatch: expected %h, got %h", text_q[0].code, out_tdata);
          err_cnt++;
        end
        if (out_tlast !== text_q[0].last) begin
          $error("last mismatch: expected %b, got %b", text_q[0].last, out_tlast);
          err_cnt++;
        end
        void'(text_q.pop_front());
        char_cnt++;
      end
    end
  end

  // receiver: random stalls, one long hold on request, none when quiet
  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else if (!quiet && rx_odds != 0 && $urandom_range(0, rx_odds) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    int hold_at;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;

    dir_value[0]  = 64'd0;                    dir_text[0]  = "0";
    dir_value[1]  = 64'd1;                    dir_text[1]  = "1";
    dir_value[2]  = -64'sd1;                  dir_text[2]  = "-1";
    dir_value[3]  = 64'd9;                    dir_text[3]  = "9";
    dir_value[4]  = 64'd10;                   dir_text[4]  = "10";
    dir_value[5]  = -64'sd9;                  dir_text[5]  = "";
    dir_value[6]  = -64'sd10;                 dir_text[6]  = "";
    dir_value[7]  = 64'd99;                   dir_text[7]  = "";
    dir_value[8]  = 64'd100;                  dir_text[8]  = "";
    dir_value[9]  = 64'd12345;                dir_text[9]  = "";
    dir_value[10] = -64'sd987654321;          dir_text[10] = "";
    dir_value[11] = 64'd999999999999999999;   dir_text[11] = "";
    dir_value[12] = 64'd1000000000000000000;  dir_text[12] = "";
    dir_value[13] = -64'sd1000000000000000000; dir_text[13] = "";
    dir_value[14] = 64'h7FFF_FFFF_FFFF_FFFF;  dir_text[14] = "9223372036854775807";
    dir_value[15] = 64'h8000_0000_0000_0000;  dir_text[15] = "-9223372036854775808";
    dir_value[16] = 64'h8000_0000_0000_0001;  dir_text[16] = "-9223372036854775807";
    dir_value[17] = 64'hFFFF_FFFF_FFFF_FFFE;  dir_text[17] = "-2";
    dir_value[18] = 64'h5555_5555_5555_5555;  dir_text[18] = "";
    dir_value[19] = 64'hAAAA_AAAA_AAAA_AAAA;  dir_text[19] = "";
    dir_value[20] = 64'h0000_0001_0000_0000;  dir_text[20] = "";
    dir_value[21] = 64'h0123_4567_89AB_CDEF;  dir_text[21] = "";

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: back to back first, light idling toward the end of the table
    for (int i = 0; i < DIR_N; i++) begin
      if (i == DIR_N / 2) begin
        tx_odds = 3;
        rx_odds = 3;
      end
      send_number(dir_value[i], dir_text[i]);
    end

    hold_at = $urandom_range(60, 140);
    for (int i = 0; i < RANDOM_N; i++) begin
      // idling density changes every 40 items, zero included
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       tx_odds = 0;
          1:       tx_odds = 2;
          default: tx_odds = 6;
        endcase
        case ($urandom_range(0, 2))
          0:       rx_odds = 0;
          1:       rx_odds = 1;
          default: rx_odds = 5;
        endcase
      end
      if (i == hold_at) hold_req = 1'b1;
      if (i == RANDOM_N - QUIET_N) quiet = 1'b1;
      send_number(random_number(), "");
    end
    in_tvalid <= 1'b0;

    while (text_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (text_q.size() != 0) begin
      $error("%0d characters never arrived", text_q.size());
      err_cnt++;
    end
    $display("Converted %0d numbers (%0d from the table) into %0d checked characters",
             num_cnt, DIR_N, char_cnt);
    $display("Covered zero, both 64-bit extremes, 1 to 19 digits, %0d-cycle output hold",
             LONG_HOLD);
    if (err_cnt == 0) begin
      $display("int64_to_decimal_ascii_core_test passed");
    end else begin
      $display("int64_to_decimal_ascii_core_test failed");
    end
    $finish;
  end

endmodule
